[rtl/dlps_pkg.sv]
// Shared constants and types for the delay line pitch shifter.
package dlps_pkg;

   // Sample store geometry
   localparam int STORE_DEPTH = 1000;
   localparam int HALF_DEPTH  = STORE_DEPTH / 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Datapath widths
   localparam int SAMPLE_W     = 16;
   localparam int WEIGHT_W     = 16;
   localparam int WEIGHT_SHIFT = 7;
   localparam int RATE_W       = 8;
   localparam int FRAC_SUM_W   = RATE_W + 1;
   localparam int PROD_W       = SAMPLE_W + WEIGHT_W + 1;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [ADDR_W:0]            addr_sum_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;
   typedef logic [RATE_W-1:0]          rate_type;
   typedef logic [FIFO_CNT_W-1:0]      fifo_cnt_type;

   localparam addr_type     DEPTH_LAST = addr_type'(STORE_DEPTH - 1);
   localparam addr_type     HALF_ADDR  = addr_type'(HALF_DEPTH);
   localparam addr_sum_type DEPTH_SUM  = addr_sum_type'(STORE_DEPTH);
   localparam rate_type     RATE_RESET = rate_type'(128);
   localparam rate_type     FRAC_RESET = rate_type'(128);

   // One weighted tap travelling from the store to the mixer
   typedef struct packed {
      logic       valid;
      logic       last;
      sample_type data;
      weight_type weight;
   } tap_type;

endpackage

[rtl/dlps_store.sv]
// Sample store, write and read sequencing, offset and rate accumulator.
module dlps_store (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  dlps_pkg::sample_type sample_in,
   input  dlps_pkg::rate_type  shift_rate,
   output logic                busy,
   output dlps_pkg::tap_type   tap_out
);
   import dlps_pkg::*;

   // Sample memory, registered read
   sample_type mem [STORE_DEPTH];
   sample_type rd_data_ff;

   // Control state
   addr_type   wp_ff, wp_in;
   addr_type   off_ff, off_in;
   rate_type   frac_ff, frac_in;
   logic       full_ff, full_in;
   logic       phase_ff, phase_in;
   logic       sec_ff, sec_in;

   // Per-item payload
   sample_type sample_ff;
   addr_type   tap1_ff;
   logic       fwd1_ff;
   weight_type w1_ff, w2_ff;
   logic       v2_ff;

   addr_type     wp_next, tap1, tap2, bound_dist, rd_addr;
   addr_sum_type tap1_sum, tap2_sum, off_sum;
   logic [FRAC_SUM_W-1:0] frac_sum;
   weight_type   w1, w2;
   logic         valid1, valid2;

   // Write position advance and first tap address
   always_comb begin
      wp_next  = (wp_ff == DEPTH_LAST) ? '0 : wp_ff + 1'b1;
      tap1_sum = {1'b0, wp_next} + {1'b0, off_ff};
      tap1     = (tap1_sum >= DEPTH_SUM) ? ADDR_W'(tap1_sum - DEPTH_SUM)
                                         : tap1_sum[ADDR_W-1:0];
   end

   // Crossfade weights from the offset's distance to the nearer boundary
   always_comb begin
      bound_dist = (off_ff > HALF_ADDR) ? ADDR_W'(DEPTH_SUM - {1'b0, off_ff}) : off_ff;
      w1         = WEIGHT_W'(bound_dist) << WEIGHT_SHIFT;
      w2         = WEIGHT_W'(HALF_ADDR - bound_dist) << WEIGHT_SHIFT;
   end

   // Rate accumulator and offset advance
   always_comb begin
      frac_sum = {1'b0, frac_ff} + {1'b0, shift_rate};
      off_sum  = {1'b0, off_ff} + addr_sum_type'(frac_sum[FRAC_SUM_W-1:WEIGHT_SHIFT]);
      off_in   = off_ff;
      frac_in  = frac_ff;
      wp_in    = wp_ff;
      full_in  = full_ff;
      if (accept) begin
         off_in  = (off_sum >= DEPTH_SUM) ? ADDR_W'(off_sum - DEPTH_SUM)
                                          : off_sum[ADDR_W-1:0];
         frac_in = RATE_W'(frac_sum[WEIGHT_SHIFT-1:0]);
         wp_in   = wp_next;
         full_in = full_ff | (wp_ff == DEPTH_LAST);
      end
   end

   // Second tap, half a store on; validity by fill state (state already updated)
   always_comb begin
      tap2_sum = {1'b0, tap1_ff} + {1'b0, HALF_ADDR};
      tap2     = (tap2_sum >= DEPTH_SUM) ? ADDR_W'(tap2_sum - DEPTH_SUM)
                                         : tap2_sum[ADDR_W-1:0];
      valid1   = full_ff | (tap1_ff < wp_ff);
      valid2   = full_ff | (tap2 < wp_ff);
      rd_addr  = phase_ff ? tap2 : tap1;
   end

   assign phase_in = accept;
   assign sec_in   = phase_ff;
   assign busy     = phase_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         off_ff   <= '0;
         frac_ff  <= FRAC_RESET;
         full_ff  <= 1'b0;
         phase_ff <= 1'b0;
         sec_ff   <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         off_ff   <= off_in;
         frac_ff  <= frac_in;
         full_ff  <= full_in;
         phase_ff <= phase_in;
         sec_ff   <= sec_in;
      end
   end

   // Per-item payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= sample_in;
         tap1_ff   <= tap1;
         fwd1_ff   <= (off_ff == DEPTH_LAST); // first tap hits the entry just written
         w1_ff     <= w1;
         w2_ff     <= w2;
      end
      if (phase_ff) begin
         v2_ff <= valid2;
      end
   end

   // Memory: write on transfer, first read alongside, second read next cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_ff] <= sample_in;
      end
      if (accept || phase_ff) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Tap stream towards the mixer
   always_comb begin
      tap_out.valid  = phase_ff | sec_ff;
      tap_out.last   = sec_ff;
      tap_out.weight = phase_ff ? w1_ff : w2_ff;
      if (phase_ff) begin
         tap_out.data = fwd1_ff ? sample_ff : (valid1 ? rd_data_ff : '0);
      end else begin
         tap_out.data = v2_ff ? rd_data_ff : '0;
      end
   end

endmodule

[rtl/dlps_mix.sv]
// Weighting multiply and crossfade sum of the two taps.
module dlps_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  dlps_pkg::tap_type    tap_in,
   output logic                 res_valid,
   output dlps_pkg::sample_type res_data
);
   import dlps_pkg::*;

   logic signed [PROD_W-1:0] prod;
   sample_type prod_hi_ff;
   sample_type acc_ff;
   logic       pv_ff, plast_ff;

   // Signed sample by unsigned weight, keep bits 31..16
   assign prod = tap_in.data * $signed({1'b0, tap_in.weight});

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff    <= 1'b0;
         plast_ff <= 1'b0;
      end else begin
         pv_ff    <= tap_in.valid;
         plast_ff <= tap_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (tap_in.valid) begin
         prod_hi_ff <= prod[2*SAMPLE_W-1:SAMPLE_W];
      end
      if (pv_ff && !plast_ff) begin
         acc_ff <= prod_hi_ff;
      end
   end

   // Sum wraps to 16 bits
   assign res_valid = pv_ff & plast_ff;
   assign res_data  = acc_ff + prod_hi_ff;

endmodule

[rtl/dlps_rsp_fifo.sv]
// Small result queue in front of the response channel.
module dlps_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dlps_pkg::sample_type push_data,
   input  logic                 pop,
   output logic                 not_empty,
   output dlps_pkg::sample_type head_data
);
   import dlps_pkg::*;

   sample_type entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   fifo_cnt_type count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

endmodule

[rtl/delay_line_pitch_shifter_core.sv]
// Top level of the delay line pitch shifter.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_sample_in  (s16)
//   rsp      out        rsp_valid / rsp_ready  rsp_sample_out (s16)
//   csr      in         csr_write_en           csr_write_data (u8, shift rate)
//
// The single read port of the sample memory serves the two taps on consecutive
// cycles, so req_ready drops in the cycle after each transfer. A response passes
// through the store's read register, the mixer's product register and the queue
// before it can transfer. Unwritten store entries read as zero via a fill flag,
// so no clearing pass is needed. A 4-entry response queue absorbs output stalls;
// besides the busy stall, requests stall only once 4 results are in flight or queued.
module delay_line_pitch_shifter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dlps_pkg::sample_type req_sample_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dlps_pkg::sample_type rsp_sample_out,
   input  logic                 csr_write_en,
   input  dlps_pkg::rate_type   csr_write_data
);
   import dlps_pkg::*;

   rate_type     shift_rate_ff;
   fifo_cnt_type credit_ff, credit_in;
   logic         accept, pop, busy, res_valid;
   tap_type      tap;
   sample_type   res_data;

   assign accept    = req_valid & req_ready;
   assign pop       = rsp_valid & rsp_ready;
   assign req_ready = !busy && (credit_ff < fifo_cnt_type'(FIFO_DEPTH));

   // Items in flight plus queued results
   always_comb begin
      credit_in = credit_ff;
      if (accept && !pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (pop && !accept) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_rate_ff <= RATE_RESET;
         credit_ff     <= '0;
      end else begin
         credit_ff <= credit_in;
         if (csr_write_en) begin
            shift_rate_ff <= csr_write_data;
         end
      end
   end

   dlps_store u_store (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample_in  (req_sample_in),
      .shift_rate (shift_rate_ff),
      .busy       (busy),
      .tap_out    (tap)
   );

   dlps_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .tap_in    (tap),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   dlps_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head_data (rsp_sample_out)
   );

endmodule

[dv/pitch_shift_checker.sv]
// Checker for the pitch shifter core: predicts each output sample and compares transfers.
`timescale 1ns / 1ps

module pitch_shift_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  dlps_pkg::sample_type req_sample_in,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dlps_pkg::sample_type rsp_sample_out,
   input  logic                 csr_write_en,
   input  dlps_pkg::rate_type   csr_write_data,
   input  logic                 run_end,
   output int                   pending,
   output int                   failures
);
   import dlps_pkg::*;

   // Own copy of the delay line and the pitch control
   sample_type delay_mem [STORE_DEPTH];
   int         wr_ptr;
   int         tap_offset;
   int         frac_acc;
   rate_type   pitch_rate;

   // Output samples predicted but not yet seen on the result channel
   sample_type shifted_due [$];

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      failures++;
   endtask

   task automatic clear_delay_line();
      foreach (delay_mem[i]) delay_mem[i] = '0;
      wr_ptr     = 0;
      tap_offset = 0;
      frac_acc   = FRAC_RESET;
      pitch_rate = RATE_RESET;
   endtask

   // Write one sample, mix the two taps, then step the playback offset
   function automatic sample_type next_shifted_sample(input sample_type s);
      int         tap;
      int         bound_dist;
      int         f;
      sample_type near_tap;
      sample_type far_tap;
      longint     near_prod;
      longint     far_prod;
      logic [SAMPLE_W-1:0] mix;
      delay_mem[wr_ptr] = s;
      wr_ptr = wr_ptr + 1;
      if (wr_ptr >= STORE_DEPTH) wr_ptr -= STORE_DEPTH;

      tap = wr_ptr + tap_offset;
      if (tap >= STORE_DEPTH) tap -= STORE_DEPTH;
      near_tap = delay_mem[tap];
      tap = tap + HALF_DEPTH;
      if (tap >= STORE_DEPTH) tap -= STORE_DEPTH;
      far_tap = delay_mem[tap];

      // distance to the nearer boundary sets the crossfade
      bound_dist = (tap_offset > HALF_DEPTH) ? STORE_DEPTH - tap_offset : tap_offset;
      near_prod = longint'(near_tap) * longint'(bound_dist << WEIGHT_SHIFT);
      far_prod  = longint'(far_tap) * longint'((HALF_DEPTH - bound_dist) << WEIGHT_SHIFT);
      // arithmetic shift keeps the floor of the high half
      mix = SAMPLE_W'((near_prod >>> 16) + (far_prod >>> 16));

      // 1.7 rate accumulator
      f = frac_acc + int'(pitch_rate);
      if (f >= 128) begin
         tap_offset += f >> 7;
         f &= 127;
      end
      frac_acc = f;
      if (tap_offset >= STORE_DEPTH) tap_offset -= STORE_DEPTH;
      return sample_type'(mix);
   endfunction

   // Follow every transfer at the clock edge; a rate write lands after the edge
   always @(posedge clock) begin : track
      sample_type due;
      if (reset) begin
         clear_delay_line();
         shifted_due.delete();
         failures = 0;
      end else begin
         if (req_valid && req_ready) shifted_due.push_back(next_shifted_sample(req_sample_in));
         if (csr_write_en) pitch_rate = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (shifted_due.size() == 0) begin
               report_mismatch($sformatf("unexpected output sample %0d", rsp_sample_out));
            end else begin
               due = shifted_due.pop_front();
               if (rsp_sample_out !== due)
                  report_mismatch($sformatf("rsp_sample_out got %0d, expected %0d",
                                            rsp_sample_out, due));
            end
         end
         if (run_end && shifted_due.size() != 0)
            report_mismatch($sformatf("%0d output samples never arrived", shifted_due.size()));
      end
      pending <= shifted_due.size();
   end

endmodule

[dv/delay_line_pitch_shifter_core_test.sv]
// Top of the pitch shifter core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module delay_line_pitch_shifter_core_test;
   import dlps_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 60;
   localparam int PRESSURE_PHASE  = 4;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   sample_type req_sample_in  = '0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   sample_type rsp_sample_out;
   logic       csr_write_en   = 1'b0;
   rate_type   csr_write_data = '0;
   logic       run_end        = 1'b0;
   logic       hold_start     = 1'b0;
   int         hold_left      = 0;
   int         cycle_count    = 0;
   int         send_idle_pct  = 0;
   int         rsp_stall_pct  = 0;
   int         pending;
   int         failures;

   delay_line_pitch_shifter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   pitch_shift_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .run_end        (run_end),
      .pending        (pending),
      .failures       (failures)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("delay_line_pitch_shifter_core verification failed");
         $finish;
      end
   end

   // Long receiver hold-off, counted here so the sender keeps offering meanwhile
   always @(posedge clock) begin
      if (hold_start) hold_left <= RSP_HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // Receiver: random stalls plus the hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Offer one sample; valid stays high after the transfer unless the next call idles
   task automatic send_sample(input sample_type s);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait for every predicted sample to come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_shift_rate(input rate_type r);
      csr_write_en   <= 1'b1;
      csr_write_data <= r;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Mostly full-scale noise, some quiet signal and rail values
   function automatic sample_type audio_sample();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         case ($urandom_range(3))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hffff;
         endcase
      end
      if (pick <= 2) return sample_type'($signed($urandom_range(511)) - 256);
      return sample_type'($urandom);
   endfunction

   sample_type edge_samples [14] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
                                     16'h5555, 16'haaaa, 16'h7fff, 16'h8000, 16'h00ff,
                                     16'hff00, 16'h4000, 16'hc000, 16'h0001};
   int         idle_send [4] = '{0, 83, 0, 28};
   int         idle_rsp  [4] = '{0, 0, 83, 28};

   initial begin : stimulus
      rate_type r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: rails and bit patterns at the reset rate
      foreach (edge_samples[i]) send_sample(edge_samples[i]);
      drain_results();

      // Zero rate freezes the offset
      write_shift_rate(8'd0);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'h1234);
      send_sample(16'hedcb);
      send_sample(16'h0000);
      drain_results();

      // Full-scale rate steps the offset by one or two
      write_shift_rate(8'd255);
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'hffff);
      send_sample(16'h0001);
      send_sample(16'h2aaa);
      drain_results();

      // Random phases with rate changes and rotating idle patterns
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: r = 8'd254;
            1: r = 8'd1;
            3: r = 8'd255;
            5: r = 8'd128;
            6: r = 8'd0;
            default: r = rate_type'($urandom_range(254, 1));
         endcase
         write_shift_rate(r);
         send_idle_pct = idle_send[p % 4];
         rsp_stall_pct = idle_rsp[p % 4];
         if (p == PRESSURE_PHASE) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) send_sample(audio_sample());
         drain_results();
      end

      // Let any stray transfer show, then close out
      repeat (8) @(posedge clock);
      run_end <= 1'b1;
      @(posedge clock);
      run_end <= 1'b0;
      @(posedge clock);
      if (failures == 0) $display("delay_line_pitch_shifter_core verification clean");
      else $display("delay_line_pitch_shifter_core verification failed");
      $finish;
   end

endmodule
